[hdl/gsg_pkg.sv]
// gsg_pkg: shared types, codes and the gaussian weight table for the splat grid
// used by the channel interfaces, the divider and the grid module of the block
`default_nettype none

package gsg_pkg;

   localparam int OP_W       = 2;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int TEMP_W     = 16;
   localparam int CONF_W     = 16;
   localparam int COUNT_W    = 10;
   localparam int WORD_W     = 1 + TEMP_W + CONF_W;
   localparam int ROM_LEN    = 2048;
   localparam int ROM_IDX_W  = $clog2(ROM_LEN);
   localparam int WEIGHT_W   = 16;
   localparam int MIN_WEIGHT = 66;
   localparam int CONF_MAX   = 40960;
   localparam int DIV_W      = 32;
   localparam int DEN_W      = 16;

   typedef enum logic [OP_W-1:0] {
      OP_UPDATE = 2'd0,
      OP_READ   = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_NOP    = 2'd3
   } op_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_ORIGIN_X  = 3'd0,
      CSR_ORIGIN_Y  = 3'd1,
      CSR_CELL_SIZE = 3'd2,
      CSR_GRID_COLS = 3'd3,
      CSR_GRID_ROWS = 3'd4,
      CSR_RADIUS    = 3'd5,
      CSR_ALPHA     = 3'd6,
      CSR_FALLOFF   = 3'd7
   } csr_addr_type;

   typedef struct packed {
      logic                      in_grid;
      logic                      cell_visited;
      logic signed [TEMP_W-1:0]  cell_temp;
      logic [CONF_W-1:0]         cell_conf;
      logic [COUNT_W-1:0]        cells_updated;
   } rsp_type;

   // one store entry: visited flag, temperature, confidence
   typedef struct packed {
      logic                      visited;
      logic signed [TEMP_W-1:0]  temp;
      logic [CONF_W-1:0]         conf;
   } word_type;

   typedef logic [WEIGHT_W-1:0] rom_type [ROM_LEN];

   // exp(-p/256) in q0.16, built at elaboration from a q0.32 step factor
   function automatic rom_type build_rom();
      logic [63:0] t;
      logic [63:0] s;
      logic [95:0] c;
      logic [95:0] e;
      logic [95:0] w;
      rom_type     rom;
      t = 64'd1 << 62;
      s = t;
      for (int n = 1; n <= 10; n++) begin
         t = t / 64'(256 * n);
         if ((n % 2) == 1) begin
            s = s - t;
         end else begin
            s = s + t;
         end
      end
      c = 96'((s + (64'd1 << 29)) >> 30);
      e = 96'd1 << 32;
      for (int p = 0; p < ROM_LEN; p++) begin
         w = (e + 96'd32768) >> 16;
         rom[p] = (w > 96'd65535) ? 16'hFFFF : w[WEIGHT_W-1:0];
         e = (e * c + (96'd1 << 31)) >> 32;
      end
      return rom;
   endfunction

   localparam rom_type WEIGHT_ROM = build_rom();

endpackage

`default_nettype wire

[hdl/gsg_if.sv]
// gsg_if: valid/ready channels of the splat grid (request, response, register write)
// depends on gsg_pkg for field widths
`default_nettype none

interface gsg_req_if import gsg_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          opcode;
   logic signed [31:0]       x_pos;
   logic signed [31:0]       y_pos;
   logic signed [TEMP_W-1:0] sample_temp;

   modport source (output valid, opcode, x_pos, y_pos, sample_temp, input ready);
   modport sink   (input valid, opcode, x_pos, y_pos, sample_temp, output ready);
endinterface

interface gsg_rsp_if import gsg_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     in_grid;
   logic                     cell_visited;
   logic signed [TEMP_W-1:0] cell_temp;
   logic [CONF_W-1:0]        cell_conf;
   logic [COUNT_W-1:0]       cells_updated;

   modport source (output valid, in_grid, cell_visited, cell_temp, cell_conf,
                   cells_updated, input ready);
   modport sink   (input valid, in_grid, cell_visited, cell_temp, cell_conf,
                   cells_updated, output ready);
endinterface

interface gsg_csr_if import gsg_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] addr;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, addr, data, input ready);
   modport sink   (input valid, addr, data, output ready);
endinterface

`default_nettype wire

[hdl/gsg_ram.sv]
// gsg_ram: generic single-write, single-read synchronous ram, registered read
// no dependencies
`default_nettype none

module gsg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             we,
   input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
   input  logic [WIDTH-1:0]                 wdata,
   input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr,
   output logic [WIDTH-1:0]                 rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

[hdl/gsg_div.sv]
// gsg_div: radix-2 restoring divider, 32-bit unsigned by 16-bit, one bit per cycle
// depends on gsg_pkg for widths
`default_nettype none

module gsg_div import gsg_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [DIV_W-1:0] quot
);

   localparam int CNT_W = $clog2(DIV_W);

   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   shifted;
   logic             fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[DIV_W-1]};
      fits    = shifted >= {1'b0, den_ff};
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         rem_in = '0;
         quo_in = num;
         // zero cell size acts as one
         den_in = (den == '0) ? DEN_W'(1) : den;
      end else if (run_ff) begin
         rem_in = fits ? DEN_W'(shifted - {1'b0, den_ff}) : shifted[DEN_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], fits};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(DIV_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule

`default_nettype wire

[hdl/gaussian_splat_ema_grid.sv]
// Gaussian splat temperature grid. One request at a time. After reset, and on every clear
// request, the block sweeps the whole store of MAX_COLS*MAX_ROWS entries (16384 at the
// defaults), one entry per cycle, and takes no request meanwhile; register writes go on.
// A read or an update first maps x, then y, to a cell with the shared bit-serial divider.
// A read then passes ST_RD_ADDR and ST_RD_DATA. An update walks (2r+1)^2 cells, each by
// read-modify-write of the single-port-pair store: ST_WALK, ST_FETCH, ST_ALPHA and ST_BLEND
// for a weighted cell in the grid, the first three for a skipped cell. A finished response
// waits in an output register while the next request is taken.
// depends on gsg_pkg, gsg_if, gsg_ram, gsg_div
`default_nettype none

module gaussian_splat_ema_grid import gsg_pkg::*; #(
   parameter int MAX_COLS   = 128,
   parameter int MAX_ROWS   = 128,
   parameter int MAX_RADIUS = 15
) (
   input  logic       clock,
   input  logic       reset,
   gsg_req_if.sink    req_ch,
   gsg_rsp_if.source  rsp_ch,
   gsg_csr_if.sink    csr_ch
);

   localparam int DEPTH  = MAX_COLS * MAX_ROWS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int RAD_W  = (MAX_RADIUS > 0) ? $clog2(MAX_RADIUS + 1) : 1;
   localparam int OFS_W  = RAD_W + 1;
   localparam int LIM_W  = ((COL_W > ROW_W) ? COL_W : ROW_W) + 1;
   localparam int SW     = ((LIM_W > RAD_W) ? LIM_W : RAD_W) + 2;
   localparam int DSQ_W  = 2 * RAD_W + 1;
   localparam int P_W    = DSQ_W + 16;

   typedef enum logic [10:0] {
      ST_CLEAR   = 11'b000_0000_0001,
      ST_IDLE    = 11'b000_0000_0010,
      ST_DIV_COL = 11'b000_0000_0100,
      ST_DIV_ROW = 11'b000_0000_1000,
      ST_RD_ADDR = 11'b000_0001_0000,
      ST_RD_DATA = 11'b000_0010_0000,
      ST_WALK    = 11'b000_0100_0000,
      ST_FETCH   = 11'b000_1000_0000,
      ST_ALPHA   = 11'b001_0000_0000,
      ST_BLEND   = 11'b010_0000_0000,
      ST_DONE    = 11'b100_0000_0000
   } state_type;

   // configuration
   logic signed [31:0] origin_x_ff, origin_y_ff;
   logic [15:0]        cell_size_ff, blend_alpha_ff, falloff_ff;
   logic [7:0]         grid_cols_ff, grid_rows_ff;
   logic [3:0]         splat_radius_ff;

   state_type              state_ff, state_in;
   logic                   ready_flag_ff, ready_flag_in;
   logic                   clr_rsp_ff, clr_rsp_in;
   logic [ADDR_W-1:0]      clr_addr_ff, clr_addr_in;
   logic [OP_W-1:0]        op_ff, op_in;
   logic signed [32:0]     dx_ff, dx_in, dy_ff, dy_in;
   logic signed [TEMP_W-1:0] sample_ff, sample_in;
   logic                   div_start_ff, div_start_in;
   logic [COL_W-1:0]       qcol_ff, qcol_in;
   logic                   col_ok_ff, col_ok_in;
   logic [ROW_W-1:0]       qrow_ff, qrow_in;
   logic [RAD_W-1:0]       rad_ff, rad_in;
   logic signed [OFS_W-1:0] dr_ff, dr_in, dc_ff, dc_in;
   logic                   cell_ok_ff, cell_ok_in;
   logic                   last_ff, last_in;
   logic [P_W-1:0]         p_ff, p_in;
   logic [ADDR_W-1:0]      addr_ff, addr_in;
   logic [WEIGHT_W-1:0]    w_ff, w_in;
   logic [15:0]            a_ff, a_in;
   word_type               old_ff, old_in;
   logic [COUNT_W-1:0]     cnt_ff, cnt_in;
   rsp_type                res_ff, res_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   // helpers
   logic [LIM_W-1:0]       cols_lim, rows_lim;
   logic [RAD_W-1:0]       rad_lim;
   logic                   div_done;
   logic [DIV_W-1:0]       div_quot;
   logic [DIV_W-1:0]       div_num;
   logic                   row_ok;
   logic signed [SW-1:0]   rs, cs;
   logic                   rs_ok, cs_ok;
   logic [2*OFS_W-1:0]     sq_r, sq_c;
   logic [DSQ_W-1:0]       dsq;
   logic [31:0]            a_prod;
   logic signed [TEMP_W:0] diff;
   logic signed [34:0]     blend_prod;
   logic signed [18:0]     step;
   logic [CONF_W:0]        conf_sum;
   word_type               new_word;
   logic                   ram_we;
   logic [ADDR_W-1:0]      ram_waddr;
   logic [WORD_W-1:0]      ram_wdata;
   logic [WORD_W-1:0]      ram_rdata;
   word_type               rd_word;
   logic                   req_fire;
   logic                   rsp_free;
   logic                   walk_end;

   gsg_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start_ff),
      .num   (div_num),
      .den   (cell_size_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   gsg_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (addr_ff),
      .rdata (ram_rdata)
   );

   assign rd_word  = word_type'(ram_rdata);
   assign div_num  = (state_ff == ST_DIV_ROW) ? dy_ff[DIV_W-1:0] : dx_ff[DIV_W-1:0];
   assign req_fire = req_ch.valid && req_ch.ready;
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;

   assign cols_lim = (32'(grid_cols_ff) > 32'(MAX_COLS)) ? LIM_W'(MAX_COLS)
                                                         : LIM_W'(grid_cols_ff);
   assign rows_lim = (32'(grid_rows_ff) > 32'(MAX_ROWS)) ? LIM_W'(MAX_ROWS)
                                                         : LIM_W'(grid_rows_ff);
   assign rad_lim  = (32'(splat_radius_ff) > 32'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS)
                                                              : RAD_W'(splat_radius_ff);

   // neighbor cell of the walk and its squared distance
   assign rs    = $signed(SW'(qrow_ff)) + SW'(dr_ff);
   assign cs    = $signed(SW'(qcol_ff)) + SW'(dc_ff);
   assign rs_ok = !rs[SW-1] && (rs < $signed(SW'(rows_lim)));
   assign cs_ok = !cs[SW-1] && (cs < $signed(SW'(cols_lim)));
   assign sq_r  = (2*OFS_W)'(dr_ff * dr_ff);
   assign sq_c  = (2*OFS_W)'(dc_ff * dc_ff);
   assign dsq   = DSQ_W'(sq_r) + DSQ_W'(sq_c);
   assign walk_end = (dr_ff == $signed({1'b0, rad_ff})) && (dc_ff == $signed({1'b0, rad_ff}));

   // blend arithmetic
   assign a_prod     = 32'(blend_alpha_ff) * 32'(w_ff) + 32'd32768;
   assign diff       = (TEMP_W+1)'(sample_ff) - (TEMP_W+1)'(old_ff.temp);
   assign blend_prod = $signed(35'({1'b0, a_ff})) * 35'(diff) + 35'sd32768;
   assign step       = 19'(blend_prod >>> 16);
   assign conf_sum   = (CONF_W+1)'(old_ff.conf)
                     + (CONF_W+1)'((17'(w_ff) + 17'd8) >> 4);

   always_comb begin
      new_word.visited = 1'b1;
      if (old_ff.visited) begin
         new_word.temp = TEMP_W'(19'(old_ff.temp) + step);
      end else begin
         new_word.temp = sample_ff;
      end
      new_word.conf = (conf_sum > (CONF_W+1)'(CONF_MAX)) ? CONF_W'(CONF_MAX)
                                                         : conf_sum[CONF_W-1:0];
   end

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = addr_ff;
      ram_wdata = WORD_W'(new_word);
      if (state_ff == ST_CLEAR) begin
         ram_we    = 1'b1;
         ram_waddr = clr_addr_ff;
         ram_wdata = '0;
      end else if (state_ff == ST_BLEND) begin
         ram_we = 1'b1;
      end
   end

   always_comb begin
      state_in      = state_ff;
      ready_flag_in = ready_flag_ff;
      clr_rsp_in    = clr_rsp_ff;
      clr_addr_in   = clr_addr_ff;
      op_in         = op_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      sample_in     = sample_ff;
      div_start_in  = 1'b0;
      qcol_in       = qcol_ff;
      col_ok_in     = col_ok_ff;
      qrow_in       = qrow_ff;
      rad_in        = rad_ff;
      dr_in         = dr_ff;
      dc_in         = dc_ff;
      cell_ok_in    = cell_ok_ff;
      last_in       = last_ff;
      p_in          = p_ff;
      addr_in       = addr_ff;
      w_in          = w_ff;
      a_in          = a_ff;
      old_in        = old_ff;
      cnt_in        = cnt_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_in        = rsp_ff;
      row_ok        = !dy_ff[32] && (div_quot < 32'(rows_lim));

      unique case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
               clr_addr_in = '0;
               if (clr_rsp_ff) begin
                  ready_flag_in = 1'b1;
                  res_in        = '0;
                  state_in      = ST_DONE;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               op_in     = req_ch.opcode;
               dx_in     = 33'(req_ch.x_pos) - 33'(origin_x_ff);
               dy_in     = 33'(req_ch.y_pos) - 33'(origin_y_ff);
               sample_in = req_ch.sample_temp;
               res_in    = '0;
               unique case (op_type'(req_ch.opcode))
                  OP_UPDATE: begin
                     if (ready_flag_ff) begin
                        div_start_in = 1'b1;
                        state_in     = ST_DIV_COL;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
                  OP_READ: begin
                     div_start_in = 1'b1;
                     state_in     = ST_DIV_COL;
                  end
                  OP_CLEAR: begin
                     clr_rsp_in = 1'b1;
                     state_in   = ST_CLEAR;
                  end
                  OP_NOP: begin
                     state_in = ST_DONE;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_DIV_COL: begin
            if (div_done) begin
               col_ok_in    = !dx_ff[32] && (div_quot < 32'(cols_lim));
               qcol_in      = div_quot[COL_W-1:0];
               div_start_in = 1'b1;
               state_in     = ST_DIV_ROW;
            end
         end
         ST_DIV_ROW: begin
            if (div_done) begin
               qrow_in = div_quot[ROW_W-1:0];
               addr_in = ADDR_W'(div_quot[ROW_W-1:0]) * ADDR_W'(MAX_COLS)
                       + ADDR_W'(qcol_ff);
               if (!(col_ok_ff && row_ok)) begin
                  res_in   = '0;
                  state_in = ST_DONE;
               end else if (op_ff == OP_READ) begin
                  state_in = ST_RD_ADDR;
               end else begin
                  rad_in   = rad_lim;
                  dr_in    = -$signed({1'b0, rad_lim});
                  dc_in    = -$signed({1'b0, rad_lim});
                  cnt_in   = '0;
                  state_in = ST_WALK;
               end
            end
         end
         ST_RD_ADDR: begin
            state_in = ST_RD_DATA;
         end
         ST_RD_DATA: begin
            res_in.in_grid       = 1'b1;
            res_in.cell_visited  = rd_word.visited;
            res_in.cell_temp     = rd_word.temp;
            res_in.cell_conf     = rd_word.conf;
            res_in.cells_updated = '0;
            state_in             = ST_DONE;
         end
         ST_WALK: begin
            cell_ok_in = rs_ok && cs_ok;
            p_in       = P_W'(dsq) * P_W'(falloff_ff);
            addr_in    = ADDR_W'(rs[ROW_W-1:0]) * ADDR_W'(MAX_COLS) + ADDR_W'(cs[COL_W-1:0]);
            last_in    = walk_end;
            if (dc_ff == $signed({1'b0, rad_ff})) begin
               dc_in = -$signed({1'b0, rad_ff});
               dr_in = dr_ff + OFS_W'(1);
            end else begin
               dc_in = dc_ff + OFS_W'(1);
            end
            state_in = ST_FETCH;
         end
         ST_FETCH: begin
            w_in     = (p_ff < P_W'(ROM_LEN)) ? WEIGHT_ROM[p_ff[ROM_IDX_W-1:0]] : '0;
            state_in = ST_ALPHA;
         end
         ST_ALPHA: begin
            a_in   = a_prod[31:16];
            old_in = rd_word;
            if (cell_ok_ff && (w_ff >= WEIGHT_W'(MIN_WEIGHT))) begin
               state_in = ST_BLEND;
            end else if (last_ff) begin
               res_in.in_grid       = 1'b1;
               res_in.cells_updated = cnt_ff;
               state_in             = ST_DONE;
            end else begin
               state_in = ST_WALK;
            end
         end
         ST_BLEND: begin
            if (cnt_ff != '1) begin
               cnt_in = cnt_ff + COUNT_W'(1);
            end
            if (last_ff) begin
               res_in.in_grid       = 1'b1;
               res_in.cells_updated = (cnt_ff != '1) ? cnt_ff + COUNT_W'(1) : cnt_ff;
               state_in             = ST_DONE;
            end else begin
               state_in = ST_WALK;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               clr_rsp_in   = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         ready_flag_ff   <= 1'b0;
         clr_rsp_ff      <= 1'b0;
         clr_addr_ff     <= '0;
         div_start_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         origin_x_ff     <= '0;
         origin_y_ff     <= '0;
         cell_size_ff    <= 16'd100;
         grid_cols_ff    <= 8'd128;
         grid_rows_ff    <= 8'd128;
         splat_radius_ff <= 4'd3;
         blend_alpha_ff  <= 16'd19661;
         falloff_ff      <= 16'd128;
      end else begin
         state_ff      <= state_in;
         ready_flag_ff <= ready_flag_in;
         clr_rsp_ff    <= clr_rsp_in;
         clr_addr_ff   <= clr_addr_in;
         div_start_ff  <= div_start_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_ch.valid) begin
            unique case (csr_addr_type'(csr_ch.addr))
               CSR_ORIGIN_X:  origin_x_ff     <= $signed(csr_ch.data);
               CSR_ORIGIN_Y:  origin_y_ff     <= $signed(csr_ch.data);
               CSR_CELL_SIZE: cell_size_ff    <= csr_ch.data[15:0];
               CSR_GRID_COLS: grid_cols_ff    <= csr_ch.data[7:0];
               CSR_GRID_ROWS: grid_rows_ff    <= csr_ch.data[7:0];
               CSR_RADIUS:    splat_radius_ff <= csr_ch.data[3:0];
               CSR_ALPHA:     blend_alpha_ff  <= csr_ch.data[15:0];
               CSR_FALLOFF:   falloff_ff      <= csr_ch.data[15:0];
               default:       falloff_ff      <= falloff_ff;
            endcase
         end
      end
      op_ff     <= op_in;
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      sample_ff <= sample_in;
      qcol_ff   <= qcol_in;
      col_ok_ff <= col_ok_in;
      qrow_ff   <= qrow_in;
      rad_ff    <= rad_in;
      dr_ff     <= dr_in;
      dc_ff     <= dc_in;
      cell_ok_ff <= cell_ok_in;
      last_ff   <= last_in;
      p_ff      <= p_in;
      addr_ff   <= addr_in;
      w_ff      <= w_in;
      a_ff      <= a_in;
      old_ff    <= old_in;
      cnt_ff    <= cnt_in;
      res_ff    <= res_in;
      rsp_ff    <= rsp_in;
   end

   assign req_ch.ready         = (state_ff == ST_IDLE);
   assign csr_ch.ready         = 1'b1;
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.in_grid       = rsp_ff.in_grid;
   assign rsp_ch.cell_visited  = rsp_ff.cell_visited;
   assign rsp_ch.cell_temp     = rsp_ff.cell_temp;
   assign rsp_ch.cell_conf     = rsp_ff.cell_conf;
   assign rsp_ch.cells_updated = rsp_ff.cells_updated;

   // store writes happen only in the clearing sweep or a weighted in-grid blend
   a_blend_qualified: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_BLEND |-> cell_ok_ff && (w_ff >= WEIGHT_W'(MIN_WEIGHT)))
      else $error("blend of a skipped cell");

   // a nonzero update count only once the grid has been cleared
   a_count_armed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.cells_updated != '0) |-> ready_flag_ff)
      else $error("update counted before clear");

   // divider results arrive only while the mapping waits on them
   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV_COL) || (state_ff == ST_DIV_ROW))
      else $error("divider result with no consumer");

   // a response is loaded only into a free output register
   a_rsp_slot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) && rsp_valid_ff && !rsp_ch.ready |=> rsp_valid_ff)
      else $error("response register overrun");

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
// tb_top: self-checking testbench for the gaussian splat temperature grid
// drives requests and register writes over gsg_if channels, predicts every response
// depends on gsg_pkg, gsg_if and the gaussian_splat_ema_grid rtl
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
   import gsg_pkg::*;

   localparam int GRID_COLS_MAX = 128;
   localparam int GRID_ROWS_MAX = 128;
   localparam int RADIUS_MAX    = 15;
   localparam int NUM_CELLS     = GRID_COLS_MAX * GRID_ROWS_MAX;
   localparam int LUT_LEN       = 2048;

   logic clock;
   logic reset;

   gsg_req_if req_if ();
   gsg_rsp_if rsp_if ();
   gsg_csr_if csr_if ();

   gaussian_splat_ema_grid u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   always #10 clock = ~clock;

   // grid model
   logic signed [15:0] grid_temp [NUM_CELLS];
   logic [15:0]        grid_conf [NUM_CELLS];
   bit                 grid_seen [NUM_CELLS];
   bit                 grid_armed;
   int                 gauss_lut [LUT_LEN];

   logic signed [31:0] cfg_origin_x, cfg_origin_y;
   int unsigned        cfg_cell_size, cfg_cols, cfg_rows, cfg_radius, cfg_alpha, cfg_falloff;

   rsp_type expected_rsp_q [$];
   int      error_count;
   int      requests_sent, responses_checked, updates_in_grid, reads_in_grid, clears_sent;
   int      send_idle_pct, recv_idle_pct, recv_hold_cycles;

   // exp(-p/256) in q0.16 from a q0.32 step factor
   function automatic void gauss_lut_init();
      longint unsigned term, acc, step;
      logic [127:0]    e;
      logic [127:0]    w;
      term = 64'd1 << 62;
      acc  = term;
      for (int n = 1; n <= 10; n++) begin
         term = term / (256 * n);
         if (n % 2) acc = acc - term;
         else acc = acc + term;
      end
      step = (acc + (64'd1 << 29)) >> 30;
      e = 128'd1 << 32;
      for (int p = 0; p < LUT_LEN; p++) begin
         w = (e + 128'd32768) >> 16;
         gauss_lut[p] = (w > 128'd65535) ? 65535 : int'(w);
         e = (e * step + (128'd1 << 31)) >> 32;
      end
   endfunction

   function automatic void grid_wipe();
      for (int i = 0; i < NUM_CELLS; i++) begin
         grid_temp[i] = '0;
         grid_conf[i] = '0;
         grid_seen[i] = 0;
      end
   endfunction

   function automatic longint floor_quot(longint num, longint den);
      longint q;
      q = num / den;
      if ((num % den) != 0 && num < 0) q = q - 1;
      return q;
   endfunction

   function automatic bit map_to_cell(logic signed [31:0] x, logic signed [31:0] y,
                                      output int row, output int col);
      longint cs, c, r, cols, rows;
      cs   = (cfg_cell_size == 0) ? 1 : cfg_cell_size;
      cols = (cfg_cols > GRID_COLS_MAX) ? GRID_COLS_MAX : cfg_cols;
      rows = (cfg_rows > GRID_ROWS_MAX) ? GRID_ROWS_MAX : cfg_rows;
      c = floor_quot(longint'(x) - longint'(cfg_origin_x), cs);
      r = floor_quot(longint'(y) - longint'(cfg_origin_y), cs);
      row = 0;
      col = 0;
      if (c < 0 || c >= cols || r < 0 || r >= rows) return 0;
      row = int'(r);
      col = int'(c);
      return 1;
   endfunction

   function automatic void blend_cell(int idx, longint sample, longint w);
      longint old, a, prod, conf;
      if (!grid_seen[idx]) begin
         grid_temp[idx] = 16'(sample);
         grid_seen[idx] = 1;
      end else begin
         old  = grid_temp[idx];
         a    = (longint'(cfg_alpha) * w + 32768) >>> 16;
         prod = a * (sample - old) + 32768;
         grid_temp[idx] = 16'(old + (prod >>> 16));
      end
      conf = longint'(grid_conf[idx]) + ((w + 8) >>> 4);
      grid_conf[idx] = 16'((conf > CONF_MAX) ? CONF_MAX : conf);
   endfunction

   function automatic int splat_update(int crow, int ccol, longint sample);
      int     rad, cols, rows, count, r, c;
      longint p, w;
      rad   = (cfg_radius > RADIUS_MAX) ? RADIUS_MAX : cfg_radius;
      cols  = (cfg_cols > GRID_COLS_MAX) ? GRID_COLS_MAX : cfg_cols;
      rows  = (cfg_rows > GRID_ROWS_MAX) ? GRID_ROWS_MAX : cfg_rows;
      count = 0;
      for (int dr = -rad; dr <= rad; dr++) begin
         for (int dc = -rad; dc <= rad; dc++) begin
            r = crow + dr;
            c = ccol + dc;
            if (r < 0 || r >= rows || c < 0 || c >= cols) continue;
            p = longint'(dr * dr + dc * dc) * cfg_falloff;
            w = (p < LUT_LEN) ? gauss_lut[p] : 0;
            if (w < MIN_WEIGHT) continue;
            blend_cell(r * GRID_COLS_MAX + c, sample, w);
            count++;
         end
      end
      return (count > 1023) ? 1023 : count;
   endfunction

   function automatic rsp_type predict_response(op_type op, logic signed [31:0] x,
                                                logic signed [31:0] y,
                                                logic signed [15:0] sample);
      rsp_type rsp;
      int      row, col, idx;
      rsp = '0;
      case (op)
         OP_UPDATE: begin
            if (grid_armed && map_to_cell(x, y, row, col)) begin
               rsp.in_grid       = 1;
               rsp.cells_updated = COUNT_W'(splat_update(row, col, longint'(sample)));
               updates_in_grid++;
            end
         end
         OP_READ: begin
            if (map_to_cell(x, y, row, col)) begin
               idx = row * GRID_COLS_MAX + col;
               rsp.in_grid      = 1;
               rsp.cell_visited = grid_seen[idx];
               rsp.cell_temp    = grid_temp[idx];
               rsp.cell_conf    = grid_conf[idx];
               reads_in_grid++;
            end
         end
         OP_CLEAR: begin
            grid_wipe();
            grid_armed = 1;
            clears_sent++;
         end
         default: ;
      endcase
      return rsp;
   endfunction

   task automatic send_request(op_type op, logic signed [31:0] x, logic signed [31:0] y,
                               logic signed [15:0] sample);
      req_if.valid       <= 1'b1;
      req_if.opcode      <= op;
      req_if.x_pos       <= x;
      req_if.y_pos       <= y;
      req_if.sample_temp <= sample;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      expected_rsp_q.push_back(predict_response(op, x, y, sample));
      requests_sent++;
      if ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // lower the request and wait until every response is back
   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_csr(csr_addr_type addr, logic [31:0] data);
      csr_if.valid <= 1'b1;
      csr_if.addr  <= addr;
      csr_if.data  <= data;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      case (addr)
         CSR_ORIGIN_X:  cfg_origin_x  = data;
         CSR_ORIGIN_Y:  cfg_origin_y  = data;
         CSR_CELL_SIZE: cfg_cell_size = data[15:0];
         CSR_GRID_COLS: cfg_cols      = data[7:0];
         CSR_GRID_ROWS: cfg_rows      = data[7:0];
         CSR_RADIUS:    cfg_radius    = data[3:0];
         CSR_ALPHA:     cfg_alpha     = data[15:0];
         CSR_FALLOFF:   cfg_falloff   = data[15:0];
         default: ;
      endcase
      csr_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_geometry(logic [31:0] ox, logic [31:0] oy, logic [15:0] cs,
                                 logic [7:0] cols, logic [7:0] rows, logic [3:0] rad);
      write_csr(CSR_ORIGIN_X, ox);
      write_csr(CSR_ORIGIN_Y, oy);
      write_csr(CSR_CELL_SIZE, {16'd0, cs});
      write_csr(CSR_GRID_COLS, {24'd0, cols});
      write_csr(CSR_GRID_ROWS, {24'd0, rows});
      write_csr(CSR_RADIUS, {28'd0, rad});
   endtask

   // position inside cell idx along one axis, may fall just outside the grid
   function automatic logic [31:0] cell_pos(logic signed [31:0] origin, int idx);
      longint cs;
      cs = (cfg_cell_size == 0) ? 1 : cfg_cell_size;
      return 32'(longint'(origin) + longint'(idx) * cs + $urandom_range(cs - 1));
   endfunction

   task automatic random_request();
      int     pick, cols, rows;
      op_type op;
      logic [31:0] x, y;
      cols = (cfg_cols > GRID_COLS_MAX) ? GRID_COLS_MAX : cfg_cols;
      rows = (cfg_rows > GRID_ROWS_MAX) ? GRID_ROWS_MAX : cfg_rows;
      pick = $urandom_range(999);
      if (pick < 700) op = OP_UPDATE;
      else if (pick < 970) op = OP_READ;
      else if (pick < 975) op = OP_CLEAR;
      else op = OP_NOP;
      if ($urandom_range(99) < 8) begin
         x = $urandom();
         y = $urandom();
      end else begin
         x = cell_pos(cfg_origin_x, $urandom_range(cols + 3) - 2);
         y = cell_pos(cfg_origin_y, $urandom_range(rows + 3) - 2);
      end
      send_request(op, x, y, 16'($urandom()));
   endtask

   task automatic random_config();
      int pick;
      logic [15:0] cs;
      logic [31:0] ox, oy;
      pick = $urandom_range(99);
      if (pick < 10) cs = 16'd1;
      else if (pick < 15) cs = 16'hFFFF;
      else cs = 16'($urandom_range(1, 1000));
      if ($urandom_range(99) < 20) begin
         ox = $urandom();
         oy = $urandom();
      end else begin
         ox = 32'($urandom_range(0, 20000) - 10000);
         oy = 32'($urandom_range(0, 20000) - 10000);
      end
      write_geometry(ox, oy, cs,
                     ($urandom_range(99) < 10) ? 8'($urandom_range(100, 255))
                                               : 8'($urandom_range(1, 24)),
                     ($urandom_range(99) < 10) ? 8'($urandom_range(100, 255))
                                               : 8'($urandom_range(1, 24)),
                     ($urandom_range(99) < 8) ? 4'd15 : 4'($urandom_range(0, 4)));
      write_csr(CSR_ALPHA, ($urandom_range(99) < 10) ? 32'hFFFF : 32'($urandom_range(0, 65535)));
      pick = $urandom_range(99);
      write_csr(CSR_FALLOFF, (pick < 5) ? 32'd0 : (pick < 10) ? 32'hFFFF
                                        : 32'($urandom_range(16, 600)));
   endtask

   task automatic test_directed();
      send_request(OP_UPDATE, 32'sd150, 32'sd150, 16'sd100);     // ignored before clear
      send_request(OP_READ, 32'sd150, 32'sd150, 16'sd0);
      send_request(OP_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
      send_request(OP_CLEAR, 32'sd0, 32'sd0, 16'sd0);
      send_request(OP_UPDATE, 32'sd0, 32'sd0, 16'sh7FFF);
      send_request(OP_UPDATE, 32'sd12799, 32'sd12799, -16'sh8000);
      send_request(OP_READ, 32'sd12799, 32'sd12799, 16'sd0);
      send_request(OP_UPDATE, 32'sd12750, 32'sd12700, 16'sh7FFF);
      send_request(OP_READ, 32'sd12799, 32'sd12799, 16'sd0);
      send_request(OP_READ, 32'sd150, 32'sd50, 16'sd0);          // row and column differ
      send_request(OP_UPDATE, -32'sd1, 32'sd500, 16'sd5);        // just left of grid
      send_request(OP_UPDATE, 32'sd12800, 32'sd500, 16'sd5);     // just right of grid
      send_request(OP_READ, 32'sd500, 32'sd12800, 16'sd0);
      send_request(OP_READ, 32'h8000_0000, 32'h7FFF_FFFF, 16'sd0);
      send_request(OP_UPDATE, 32'h7FFF_FFFF, 32'h8000_0000, 16'sd1);
      send_request(OP_UPDATE, 32'sd6400, 32'sd6400, 16'sd320);
      for (int i = 0; i < 6; i++) send_request(OP_UPDATE, 32'sd6420, 32'sd6480, 16'sd999);
      send_request(OP_READ, 32'sd6400, 32'sd6400, 16'sd0);       // confidence grows
      drain();
   endtask

   task automatic test_register_extremes();
      // zero cell size acts as one, huge grid clamps, zero falloff weights every cell
      write_geometry(32'h8000_0000, 32'h7FFF_FF00, 16'd0, 8'd255, 8'd200, 4'd15);
      write_csr(CSR_FALLOFF, 32'd0);
      write_csr(CSR_ALPHA, 32'hFFFF);
      send_request(OP_UPDATE, 32'h8000_0000 + 32'd64, 32'h7FFF_FF40, 16'sd77);
      send_request(OP_UPDATE, 32'h8000_0000 + 32'd60, 32'h7FFF_FF40, -16'sd77);
      send_request(OP_READ, 32'h8000_0000 + 32'd60, 32'h7FFF_FF4F, 16'sd0);
      for (int i = 0; i < 40; i++)                               // saturate confidence
         send_request(OP_UPDATE, 32'h8000_0000 + 32'd10, 32'h7FFF_FF05, 16'sd9);
      send_request(OP_READ, 32'h8000_0000 + 32'd10, 32'h7FFF_FF05, 16'sd0);
      drain();
      write_csr(CSR_FALLOFF, 32'hFFFF);
      write_csr(CSR_ALPHA, 32'd0);
      write_geometry(32'h7FFF_0000, 32'hFFFF_0000, 16'hFFFF, 8'd1, 8'd1, 4'd0);
      send_request(OP_UPDATE, 32'h7FFF_1234, 32'hFFFF_FFFF, 16'sd3);
      send_request(OP_UPDATE, 32'h7FFF_1234, 32'hFFFF_FFFF, 16'sd300);
      send_request(OP_READ, 32'h7FFF_FFFF, 32'hFFFF_0000, 16'sd0);
      drain();
      write_geometry(32'd0, 32'd0, 16'd10, 8'd0, 8'd5, 4'd2);     // no columns at all
      send_request(OP_UPDATE, 32'd5, 32'd5, 16'sd3);
      send_request(OP_READ, 32'd5, 32'd5, 16'sd0);
      drain();
   endtask

   task automatic test_random_phase(int items, int s_idle, int r_idle);
      send_idle_pct = s_idle;
      recv_idle_pct = r_idle;
      for (int i = 0; i < items; i++) begin
         if (i % 100 == 0) begin
            drain();
            random_config();
            if ($urandom_range(3) == 0) send_request(OP_CLEAR, '0, '0, '0);
         end
         random_request();
      end
      drain();
   endtask

   task automatic test_backpressure();
      send_idle_pct    = 0;
      recv_idle_pct    = 0;
      recv_hold_cycles = 3000;
      for (int i = 0; i < 8; i++) random_request();
      drain();
   endtask

   // response sink with random stalls and a long hold on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (recv_hold_cycles > 0) begin
         rsp_if.ready     <= 1'b0;
         recv_hold_cycles <= recv_hold_cycles - 1;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_rsp_q.size() == 0) begin
            $display("%0t: unexpected response in_grid=%0d cells_updated=%0d", $time,
                     rsp_if.in_grid, rsp_if.cells_updated);
            error_count++;
         end else begin
            exp_rsp = expected_rsp_q.pop_front();
            responses_checked++;
            if (rsp_if.in_grid !== exp_rsp.in_grid) begin
               $display("%0t: in_grid expected %0d actual %0d", $time,
                        exp_rsp.in_grid, rsp_if.in_grid);
               error_count++;
            end
            if (rsp_if.cell_visited !== exp_rsp.cell_visited) begin
               $display("%0t: cell_visited expected %0d actual %0d", $time,
                        exp_rsp.cell_visited, rsp_if.cell_visited);
               error_count++;
            end
            if (rsp_if.cell_temp !== exp_rsp.cell_temp) begin
               $display("%0t: cell_temp expected %0d actual %0d", $time,
                        exp_rsp.cell_temp, rsp_if.cell_temp);
               error_count++;
            end
            if (rsp_if.cell_conf !== exp_rsp.cell_conf) begin
               $display("%0t: cell_conf expected %0d actual %0d", $time,
                        exp_rsp.cell_conf, rsp_if.cell_conf);
               error_count++;
            end
            if (rsp_if.cells_updated !== exp_rsp.cells_updated) begin
               $display("%0t: cells_updated expected %0d actual %0d", $time,
                        exp_rsp.cells_updated, rsp_if.cells_updated);
               error_count++;
            end
         end
      end
   end

   initial begin
      #(160_000_000);
      $display("timeout with %0d responses outstanding", expected_rsp_q.size());
      $display("FAIL gaussian_splat_ema_grid");
      $finish;
   end

   initial begin
      clock              = 1'b0;
      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.opcode      = '0;
      req_if.x_pos       = '0;
      req_if.y_pos       = '0;
      req_if.sample_temp = '0;
      csr_if.valid       = 1'b0;
      csr_if.addr        = '0;
      csr_if.data        = '0;
      error_count        = 0;
      requests_sent      = 0;
      responses_checked  = 0;
      updates_in_grid    = 0;
      reads_in_grid      = 0;
      clears_sent        = 0;
      send_idle_pct      = 7;
      recv_idle_pct      = 61;
      recv_hold_cycles   = 0;
      cfg_origin_x       = 0;
      cfg_origin_y       = 0;
      cfg_cell_size      = 100;
      cfg_cols           = 128;
      cfg_rows           = 128;
      cfg_radius         = 3;
      cfg_alpha          = 19661;
      cfg_falloff        = 128;
      grid_armed         = 0;
      gauss_lut_init();
      grid_wipe();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_register_extremes();
      test_random_phase(550, 7, 61);
      test_random_phase(550, 61, 7);
      test_backpressure();
      test_random_phase(500, 0, 0);
      drain();
      repeat (200) @(posedge clock);

      $display("covered %0d requests, %0d responses: %0d in-grid updates, %0d in-grid reads,",
               requests_sent, responses_checked, updates_in_grid, reads_in_grid);
      $display("%0d clears, register extremes and a long response stall", clears_sent);
      if (error_count == 0 && expected_rsp_q.size() == 0) begin
         $display("PASS gaussian_splat_ema_grid");
      end else begin
         $display("FAIL gaussian_splat_ema_grid");
      end
      $finish;
   end

endmodule

`default_nettype wire

[files.f]
hdl/gsg_pkg.sv
hdl/gsg_if.sv
hdl/gsg_ram.sv
hdl/gsg_div.sv
hdl/gaussian_splat_ema_grid.sv
tb/sv/tb_top.sv
